// ===== rtl/core/pls_pkg.sv =====
`default_nettype none
package pls_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int CMD_W        = 3;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_POS   = 3'd5,
        CMD_READ_ALL  = 3'd6,
        CMD_NOP       = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_RANGE = 2'd2,
        STS_FULL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/pls_cell.sv =====
`default_nettype none
module pls_cell #(
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                               clk,
    input  pls_pkg::cell_ctl_t                 ctl,
    input  logic [IDX_W-1:0]                   idx,
    input  logic [IDX_W-1:0]                   last_idx,
    input  logic signed [pls_pkg::DATA_W-1:0]  left_data,
    input  logic signed [pls_pkg::DATA_W-1:0]  right_data,
    input  logic signed [pls_pkg::DATA_W-1:0]  head_data,
    output logic signed [pls_pkg::DATA_W-1:0]  data
);
    import pls_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INS:
            begin
                if (MY_IDX == idx)
                begin
                    data_next = ctl.value;
                end
                else if (MY_IDX > idx)
                begin
                    data_next = left_data;
                end
            end
            CELL_DEL:
            begin
                if (MY_IDX >= idx)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROT:
            begin
                if (MY_IDX == last_idx)
                begin
                    data_next = head_data;
                end
                else if (MY_IDX < last_idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/positional_list_store.sv =====
// Positional list store: an ordered list of up to CAPACITY signed 32-bit
// values addressed by 1-based positions.
// Input channel (in_valid / in_stall) carries one command beat: cmd, value,
// position. Output channel (out_valid / out_stall) carries result beats:
// status, element, last, length.
// Insert and delete commands give one result beat, which appears in the
// output register the cycle after the command is accepted.
// A new command may be accepted every cycle while the output register is
// free or being drained. Every cell shifts at once, so an insert or delete
// costs the same anywhere in the list.
// A read-out rotates the cell chain once per entry and streams one beat per
// cycle while out_stall allows, count beats in all (one empty-status beat on
// an empty list); no command is accepted until its last beat is in the output
// register. While out_stall is high and a beat is held, the output register
// holds that beat, in_stall rises and the chain holds.
// Reset empties the list and clears out_valid; entry contents are not reset.
`default_nettype none
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::DEF_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [pls_pkg::CMD_W-1:0]            cmd,
    input  logic signed [pls_pkg::DATA_W-1:0]    value,
    input  logic [pls_pkg::POS_W-1:0]            position,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [pls_pkg::STATUS_W-1:0]         status,
    output logic signed [pls_pkg::DATA_W-1:0]    element,
    output logic                                 last,
    output logic [pls_pkg::LEN_W-1:0]            length
);
    import pls_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = POS_W + 2;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         rd_idx_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic signed [DATA_W-1:0] element_reg;
    logic signed [DATA_W-1:0] element_next;
    logic                     last_reg;
    logic                     last_next;
    logic [LEN_W-1:0]         length_reg;
    logic [LEN_W-1:0]         length_next;

    cell_ctl_t                ctl;
    logic [IDX_W-1:0]         op_idx;
    logic [IDX_W-1:0]         last_idx;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    logic                     out_free;
    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic [IDX_W-1:0]         pos_idx;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;
    assign is_full  = (count_reg >= CAP_CNT);
    assign is_empty = (count_reg == '0);
    assign pos_ext  = CMP_W'(position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_idx  = IDX_W'(position - POS_W'(1));
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        element_next   = element_reg;
        last_next      = last_reg;
        length_next    = length_reg;
        ctl.op         = CELL_HOLD;
        ctl.value      = value;
        op_idx         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = STS_OK;
                    element_next   = '0;
                    last_next      = 1'b1;
                    case (cmd_t'(cmd))
                        CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_POS:
                        begin
                            if (is_full)
                            begin
                                status_next = STS_FULL;
                            end
                            else if (cmd_t'(cmd) == CMD_INS_FRONT)
                            begin
                                ctl.op     = CELL_INS;
                                op_idx     = '0;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else if (cmd_t'(cmd) == CMD_INS_BACK)
                            begin
                                ctl.op     = CELL_INS;
                                op_idx     = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                            else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                            begin
                                status_next = STS_RANGE;
                            end
                            else
                            begin
                                ctl.op     = CELL_INS;
                                op_idx     = pos_idx;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS:
                        begin
                            if (is_empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (cmd_t'(cmd) == CMD_DEL_FRONT)
                            begin
                                ctl.op     = CELL_DEL;
                                op_idx     = '0;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else if (cmd_t'(cmd) == CMD_DEL_BACK)
                            begin
                                ctl.op     = CELL_DEL;
                                op_idx     = last_idx;
                                count_next = count_reg - CNT_W'(1);
                            end
                            else if (pos_ext == '0 || pos_ext > cnt_ext)
                            begin
                                status_next = STS_RANGE;
                            end
                            else
                            begin
                                ctl.op     = CELL_DEL;
                                op_idx     = pos_idx;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_READ_ALL:
                        begin
                            if (is_empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                rd_idx_next    = '0;
                                state_next     = ST_READ;
                            end
                        end
                        default:
                        begin
                            status_next = STS_OK;
                        end
                    endcase
                    length_next = LEN_W'(count_next);
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    ctl.op         = CELL_ROT;
                    out_valid_next = 1'b1;
                    status_next    = STS_OK;
                    element_next   = cell_data[0];
                    last_next      = (rd_idx_reg == last_idx);
                    length_next    = LEN_W'(count_reg);
                    rd_idx_next    = rd_idx_reg + IDX_W'(1);
                    if (rd_idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
        length_reg  <= length_next;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pls_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .idx        (op_idx),
            .last_idx   (last_idx),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;
    assign length    = length_reg;

endmodule
`default_nettype wire
